/* rtl/core/led_indicator_effect_engine_assert.svh */
// ----------------------------------------------------------------------------
// LED indicator effect engine - assertion macros
// Concurrent checks clocked on i_clk, inactive while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LED_INDICATOR_EFFECT_ENGINE_ASSERT_SVH
`define LED_INDICATOR_EFFECT_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge
`define LIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define LIE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define LIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LIE_ASSERT(lbl, prop, msg)
`define LIE_ASSERT_IMPL(lbl, ante, cons, msg)
`define LIE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/lie_pkg.sv */
// ----------------------------------------------------------------------------
// LED indicator effect engine - package
// Shared constants, codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lie_pkg;

    // input opcodes
    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_TRIGGER = 2'd1;
    localparam logic [1:0] OP_MOTION  = 2'd2;

    // effect modes
    localparam logic [2:0] MODE_SOLID   = 3'd0;
    localparam logic [2:0] MODE_BREATH  = 3'd1;
    localparam logic [2:0] MODE_REACT   = 3'd2;
    localparam logic [2:0] MODE_RAINBOW = 3'd3;
    localparam logic [2:0] MODE_OFF     = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MACRO_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BREATH_SPD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_MOTION  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TIMEOUT = 3'd6;

    localparam logic [31:0] FLASH_MS      = 32'd300;
    localparam logic [7:0]  BRIGHT_RESET  = 8'hFF;
    localparam logic [7:0]  SPEED_RESET   = 8'd1;
    localparam logic [1:0]  LAST_CHANNEL  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       acc;        // input transfer this cycle
        logic       prep;       // advance phase, pick source colour
        logic       mul_en;     // scale one channel
        logic [1:0] mul_ch;     // channel being scaled, 0 is blue
        logic       sel_factor; // multiply by breathing factor, not brightness
        logic       out_load;   // load the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_update;   // offered item is an update
        logic need_scale;  // mode uses brightness scaling
        logic need_second; // mode applies the breathing factor as well
        logic out_free;    // output register free by the next edge
    } t_dp_status;

endpackage

/* rtl/core/led_indicator_effect_engine.sv */
// ----------------------------------------------------------------------------
// LED indicator effect engine - top level
// Produces one RGB colour per update item for the selected lighting effect.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): opcode and millisecond time stamp.
//   Update items give one colour; trigger and motion items only change state.
// Output channel (o_valid / i_stall): 24-bit colour, red in bits 23:16.
// Configuration channel (i_cfg_valid / o_cfg_ready): register index and data,
//   always ready; write only while no update is in flight or undelivered.
// Input stalls until an update is loaded. Trigger and motion items take only
//   their transfer; solid or off prepare and load; reactive or rainbow add a
//   brightness pass, breathing a second one. The colour shows on o_valid in
//   the cycle after its load. One shared 8x8 multiplier scales one channel
//   per cycle, once for brightness and once more for the breathing factor.
// A finished colour waits in the output register, while the engine is free
//   to take trigger and motion items and to work on the next update; when it
//   is done it holds until the output register is taken.
// Reset (synchronous, active low) restores register defaults (brightness
//   255, breathing speed 1, others 0) and clears phase and timers.
// ----------------------------------------------------------------------------
module led_indicator_effect_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [31:0]                   i_now_ms,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [23:0]                   o_color,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lie_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    lie_pkg::t_dp_cmd    cmd;
    lie_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    lie_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // registers, multiplier and output
    lie_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_opcode    (i_opcode),
        .i_now_ms    (i_now_ms),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_color     (o_color)
    );

endmodule

/* rtl/core/lie_datapath.sv */
// ----------------------------------------------------------------------------
// LED indicator effect engine - datapath
// Configuration registers, effect state, shared 8x8 channel multiplier and
// the output register.
// ----------------------------------------------------------------------------
module lie_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lie_pkg::t_dp_cmd              i_cmd,
    output lie_pkg::t_dp_status           o_status,
    input  logic [1:0]                    i_opcode,
    input  logic [31:0]                   i_now_ms,
    input  logic                          i_cfg_valid,
    input  logic [lie_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [23:0]                   o_color
);

    // configuration
    logic [23:0] r_base_color;
    logic [23:0] r_macro_color;
    logic [7:0]  r_brightness;
    logic [2:0]  r_effect_mode;
    logic [7:0]  r_breath_speed;
    logic        r_off_on_motion;
    logic [31:0] r_off_timeout;

    // effect state
    logic [17:0] r_phase;
    logic        r_react_act;
    logic [31:0] r_react_start;
    logic [31:0] r_last_motion;

    // working registers
    logic [31:0] r_now;
    logic [23:0] r_work;
    logic [7:0]  r_factor;
    logic        r_blank;
    logic        r_out_valid;

    logic [17:0] n_phase;
    logic [7:0]  k;
    logic [7:0]  h;
    logic [7:0]  n_factor;
    logic [31:0] react_age;
    logic [31:0] motion_age;
    logic        in_window;
    logic        n_blank;
    logic [23:0] n_src;
    logic [7:0]  mul_a;
    logic [7:0]  mul_b;
    logic [15:0] product;

    // status
    assign o_status.in_update   = (i_opcode == lie_pkg::OP_UPDATE);
    assign o_status.need_scale  = r_effect_mode inside {lie_pkg::MODE_BREATH,
                                                        lie_pkg::MODE_REACT,
                                                        lie_pkg::MODE_RAINBOW};
    assign o_status.need_second = (r_effect_mode == lie_pkg::MODE_BREATH);
    assign o_status.out_free    = !r_out_valid || !i_stall;

    // phase advance and breathing triangle
    assign n_phase  = r_phase + {10'd0, r_breath_speed};
    assign k        = n_phase[15:8];
    assign h        = n_phase[17:10];
    assign n_factor = k[7] ? {~k[6:0], 1'b0} : {k[6:0], 1'b0};

    // time windows, modulo 2^32
    assign react_age  = r_now - r_react_start;
    assign motion_age = r_now - r_last_motion;
    assign in_window  = r_react_act && (react_age < lie_pkg::FLASH_MS);
    assign n_blank    = r_off_on_motion && (r_off_timeout != 32'd0)
                     && (motion_age > r_off_timeout);

    // source colour for the effect
    always_comb begin
        case (r_effect_mode)
            lie_pkg::MODE_BREATH:  n_src = r_base_color;
            lie_pkg::MODE_REACT:   n_src = in_window ? r_macro_color : r_base_color;
            lie_pkg::MODE_RAINBOW: n_src = {h, ~h, 1'b0, h[7:1]};
            lie_pkg::MODE_OFF:     n_src = 24'd0;
            default:               n_src = r_base_color;
        endcase
    end

    // shared channel multiplier
    assign mul_a   = r_work[{i_cmd.mul_ch, 3'b000} +: 8];
    assign mul_b   = i_cmd.sel_factor ? r_factor : r_brightness;
    assign product = mul_a * mul_b;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_color    <= 24'd0;
            r_macro_color   <= 24'd0;
            r_brightness    <= lie_pkg::BRIGHT_RESET;
            r_effect_mode   <= lie_pkg::MODE_SOLID;
            r_breath_speed  <= lie_pkg::SPEED_RESET;
            r_off_on_motion <= 1'b0;
            r_off_timeout   <= 32'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lie_pkg::REG_BASE_COLOR:  r_base_color    <= i_cfg_data[23:0];
                lie_pkg::REG_MACRO_COLOR: r_macro_color   <= i_cfg_data[23:0];
                lie_pkg::REG_BRIGHTNESS:  r_brightness    <= i_cfg_data[7:0];
                lie_pkg::REG_EFFECT_MODE: r_effect_mode   <= i_cfg_data[2:0];
                lie_pkg::REG_BREATH_SPD: begin
                    if (i_cfg_data[7:0] != 8'd0) r_breath_speed <= i_cfg_data[7:0];
                end
                lie_pkg::REG_OFF_MOTION:  r_off_on_motion <= i_cfg_data[0];
                lie_pkg::REG_OFF_TIMEOUT: r_off_timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effect state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= 18'd0;
            r_react_act   <= 1'b0;
            r_react_start <= 32'd0;
            r_last_motion <= 32'd0;
        end else if (i_cmd.acc) begin
            if (i_opcode == lie_pkg::OP_TRIGGER) begin
                r_react_act   <= 1'b1;
                r_react_start <= i_now_ms;
            end
            if (i_opcode == lie_pkg::OP_MOTION) r_last_motion <= i_now_ms;
        end else if (i_cmd.prep) begin
            r_phase <= n_phase;
            if ((r_effect_mode == lie_pkg::MODE_REACT) && !in_window) r_react_act <= 1'b0;
        end
    end

    // working colour: load source, then scale channel by channel
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) r_now <= i_now_ms;
        if (i_cmd.prep) begin
            r_work   <= n_src;
            r_factor <= n_factor;
            r_blank  <= n_blank;
        end else if (i_cmd.mul_en) begin
            r_work[{i_cmd.mul_ch, 3'b000} +: 8] <= product[15:8];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) o_color <= r_blank ? 24'd0 : r_work;
    end

    assign o_valid = r_out_valid;

endmodule

/* rtl/core/lie_ctrl.sv */
// ----------------------------------------------------------------------------
// LED indicator effect engine - controller
// Sequences one update: preparation, brightness pass if scaled, breathing pass
// if breathing, output load. Trigger and motion items complete at transfer.
// ----------------------------------------------------------------------------
`include "led_indicator_effect_engine_assert.svh"

module lie_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  lie_pkg::t_dp_status  i_status,
    output lie_pkg::t_dp_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_ch;
    logic [1:0] n_ch;
    logic       acc;
    logic       in_mul;

    assign o_stall = (r_state != S_IDLE);
    assign acc     = i_valid && !o_stall;
    assign in_mul  = r_state inside {S_MUL1, S_MUL2};

    // next state and commands
    always_comb begin
        n_state          = r_state;
        n_ch             = r_ch;
        o_cmd            = '0;
        o_cmd.acc        = acc;
        o_cmd.mul_ch     = r_ch;
        case (r_state)
            S_IDLE: begin
                if (acc && i_status.in_update) n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_ch       = 2'd0;
                n_state    = i_status.need_scale ? S_MUL1 : S_DONE;
            end
            S_MUL1: begin
                o_cmd.mul_en = 1'b1;
                if (r_ch == lie_pkg::LAST_CHANNEL) begin
                    n_ch    = 2'd0;
                    n_state = i_status.need_second ? S_MUL2 : S_DONE;
                end else begin
                    n_ch = r_ch + 2'd1;
                end
            end
            S_MUL2: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.sel_factor = 1'b1;
                if (r_ch == lie_pkg::LAST_CHANNEL) begin
                    n_ch    = 2'd0;
                    n_state = S_DONE;
                end else begin
                    n_ch = r_ch + 2'd1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    // checks
    `LIE_ASSERT_IMPL(a_load_free, o_cmd.out_load, i_status.out_free, "output overwritten")
    `LIE_ASSERT(a_ch_range, r_ch != 2'd3, "channel counter out of range")
    `LIE_ASSERT_NEXT(a_update_prep, acc && i_status.in_update, r_state == S_PREP, "update lost")
    `LIE_ASSERT_IMPL(a_mul_scaled, in_mul, i_status.need_scale, "scaling in unscaled mode")

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// LED indicator effect engine - self-checking testbench
// Drives opcode and time stamp transfers through the input channel and
// programs the seven registers between runs. A behavioural model of the
// engine predicts each colour and the output channel is checked in order.
// The run has two parts. A short directed plan covers register extremes,
// every effect, the unused codes, the reactive window and motion blanking
// across the time wrap. Ten randomised phases follow under random back
// pressure, and one phase includes a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // codes the block leaves unused
    localparam logic [1:0] OP_SPARE      = 2'd3;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int unsigned N_PHASES        = 10;
    localparam int unsigned ITEMS_PER_PHASE = 100;
    localparam int unsigned HOLD_PHASE      = 2;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned SETTLE_CYCLES   = 12;
    localparam int unsigned END_WAIT_LIMIT  = 20000;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [lie_pkg::CFG_IDX_W-1:0] idx;
        logic [1:0]                    op;
        logic [31:0]                   data;    // time stamp or register value
        bit                            typed;   // colour below is the known answer
        logic [23:0]                   colour;
    } t_plan_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [1:0]                    i_opcode;
    logic [31:0]                   i_now_ms;
    logic                          o_valid;
    logic                          i_stall;
    logic [23:0]                   o_color;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [lie_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                   i_cfg_data;

    // receiver back pressure: random pattern plus one long hold-off
    logic rx_rand;
    logic rx_hold;
    bit   hold_req;
    assign i_stall = rx_rand | rx_hold;

    // model copy of the registers
    logic [23:0] reg_base;
    logic [23:0] reg_macro;
    logic [7:0]  reg_bright;
    logic [2:0]  reg_mode;
    logic [7:0]  reg_speed;
    logic        reg_blank_en;
    logic [31:0] reg_blank_ms;

    // model copy of the engine state
    logic [17:0] phase_acc;
    logic        flash_on;
    logic [31:0] flash_start_ms;
    logic [31:0] motion_ms;

    logic [23:0]  colour_due [$];
    t_plan_row    plan [$];
    logic [2:0]   phase_modes [N_PHASES] = '{lie_pkg::MODE_BREATH, lie_pkg::MODE_REACT,
        lie_pkg::MODE_REACT, lie_pkg::MODE_RAINBOW, lie_pkg::MODE_SOLID,
        lie_pkg::MODE_BREATH, lie_pkg::MODE_OFF, MODE_SPARE_HI,
        lie_pkg::MODE_RAINBOW, lie_pkg::MODE_REACT};
    int unsigned  mismatch_count;
    int unsigned  cycle_count;

    led_indicator_effect_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_now_ms    (i_now_ms),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_color     (o_color),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        mismatch_count++;
        $display("mismatch: %s: got %06h want %06h, cycle %0d",
                 what, got, want, cycle_count);
    endtask

    // per channel: channel * mul >> 8
    function automatic logic [23:0] scale_rgb(input logic [23:0] rgb,
                                              input logic [7:0] mul);
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        r = rgb[23:16] * mul;
        g = rgb[15:8] * mul;
        b = rgb[7:0] * mul;
        return {r[15:8], g[15:8], b[15:8]};
    endfunction

    // engine behaviour for one item; returns 1 when a colour is produced
    function automatic bit engine_step(input logic [1:0] op, input logic [31:0] now,
                                       output logic [23:0] colour);
        logic [7:0] k;
        logic [7:0] factor;
        logic [7:0] h;
        colour = '0;
        if (op == lie_pkg::OP_TRIGGER) begin
            flash_on       = 1'b1;
            flash_start_ms = now;
            return 1'b0;
        end
        if (op == lie_pkg::OP_MOTION) begin
            motion_ms = now;
            return 1'b0;
        end
        if (op != lie_pkg::OP_UPDATE)
            return 1'b0;

        phase_acc = phase_acc + 18'(reg_speed);
        case (reg_mode)
            lie_pkg::MODE_BREATH: begin
                // triangle over phase bits 15:8
                k      = phase_acc[15:8];
                factor = k[7] ? 8'((8'd255 - k) << 1) : 8'(k << 1);
                colour = scale_rgb(scale_rgb(reg_base, reg_bright), factor);
            end
            lie_pkg::MODE_REACT: begin
                if (flash_on && (now - flash_start_ms) < lie_pkg::FLASH_MS) begin
                    colour = scale_rgb(reg_macro, reg_bright);
                end else begin
                    flash_on = 1'b0;
                    colour   = scale_rgb(reg_base, reg_bright);
                end
            end
            lie_pkg::MODE_RAINBOW: begin
                h      = phase_acc[17:10];
                colour = scale_rgb({h, 8'd255 - h, 1'b0, h[7:1]}, reg_bright);
            end
            lie_pkg::MODE_OFF: colour = '0;
            default:           colour = reg_base;
        endcase

        // blank after motion inactivity
        if (reg_blank_en && reg_blank_ms != 0 && (now - motion_ms) > reg_blank_ms)
            colour = '0;
        return 1'b1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_plan_row cfg_row(input logic [lie_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [31:0] data);
        return '{kind: ROW_CFG, idx: idx, op: lie_pkg::OP_UPDATE, data: data,
                 typed: 1'b0, colour: 24'h0};
    endfunction

    function automatic t_plan_row item_row(input logic [1:0] op, input logic [31:0] now,
                                           input bit typed, input logic [23:0] colour);
        return '{kind: ROW_ITEM, idx: lie_pkg::REG_BASE_COLOR, op: op, data: now,
                 typed: typed, colour: colour};
    endfunction

    // one input transfer; entered and left just after a falling edge
    task automatic send_item(input logic [1:0] op, input logic [31:0] now,
                             input int unsigned gap, input bit typed,
                             input logic [23:0] typed_colour);
        logic [23:0] colour;
        bit          produced;
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_opcode = op;
        i_now_ms = now;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        produced = engine_step(op, now, colour);
        if (produced)
            colour_due.push_back(typed ? typed_colour : colour);
    endtask

    // register write through the configuration channel
    task automatic cfg_write(input logic [lie_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lie_pkg::REG_BASE_COLOR:  reg_base     = data[23:0];
            lie_pkg::REG_MACRO_COLOR: reg_macro    = data[23:0];
            lie_pkg::REG_BRIGHTNESS:  reg_bright   = data[7:0];
            lie_pkg::REG_EFFECT_MODE: reg_mode     = data[2:0];
            lie_pkg::REG_BREATH_SPD:  if (data[7:0] != 0) reg_speed = data[7:0];
            lie_pkg::REG_OFF_MOTION:  reg_blank_en = data[0];
            lie_pkg::REG_OFF_TIMEOUT: reg_blank_ms = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop offering, let every colour out and the engine go quiet
    task automatic settle_engine();
        i_valid = 1'b0;
        while (colour_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // output checking
    always @(posedge i_clk) begin
        logic [23:0] due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (colour_due.size() == 0) begin
                report_mismatch("colour with none due", o_color, 24'h0);
            end else begin
                due = colour_due.pop_front();
                if (o_color !== due)
                    report_mismatch("colour", o_color, due);
            end
        end
    end

    // random receiver stalls, with quiet stretches
    initial begin
        int unsigned n;
        rx_rand = 1'b0;
        forever begin
            n = pick_gap();
            repeat (n) begin
                @(negedge i_clk);
                rx_rand = 1'b1;
            end
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 4);
            repeat (n) begin
                @(negedge i_clk);
                rx_rand = 1'b0;
            end
        end
    end

    // one long hold-off so the engine fills and stalls its input
    initial begin
        int unsigned held;
        rx_hold = 1'b0;
        wait (hold_req);
        @(negedge i_clk);
        rx_hold = 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++)
            @(negedge i_clk);
        rx_hold = 1'b0;
    end

    // stimulus and end of run
    initial begin
        logic [31:0] clk_ms;
        logic [31:0] now;
        logic [31:0] timeout;
        logic [1:0]  op;
        int unsigned roll;
        int unsigned done;
        int unsigned waited;
        int unsigned p;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_opcode    = lie_pkg::OP_UPDATE;
        i_now_ms    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = lie_pkg::REG_BASE_COLOR;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;

        reg_base       = '0;
        reg_macro      = '0;
        reg_bright     = lie_pkg::BRIGHT_RESET;
        reg_mode       = lie_pkg::MODE_SOLID;
        reg_speed      = lie_pkg::SPEED_RESET;
        reg_blank_en   = 1'b0;
        reg_blank_ms   = '0;
        phase_acc      = '0;
        flash_on       = 1'b0;
        flash_start_ms = '0;
        motion_ms      = '0;

        // directed plan
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h0, 1'b1, 24'h000000));
        plan.push_back(cfg_row(lie_pkg::REG_BASE_COLOR, 32'hFF_FFFF));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h1, 1'b1, 24'hFFFFFF));
        plan.push_back(cfg_row(lie_pkg::REG_EFFECT_MODE, {29'h0, lie_pkg::MODE_OFF}));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 24'h000000));
        plan.push_back(cfg_row(lie_pkg::REG_EFFECT_MODE, {29'h0, MODE_SPARE_HI}));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h2, 1'b1, 24'hFFFFFF));
        plan.push_back(cfg_row(lie_pkg::REG_EFFECT_MODE, {29'h0, MODE_SPARE_LO}));
        plan.push_back(item_row(OP_SPARE, 32'h3, 1'b0, 24'h0));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h4, 1'b1, 24'hFFFFFF));
        // reactive window, including a trigger just before the time wrap
        plan.push_back(cfg_row(lie_pkg::REG_MACRO_COLOR, 32'hFF_00FF));
        plan.push_back(cfg_row(lie_pkg::REG_EFFECT_MODE, {29'h0, lie_pkg::MODE_REACT}));
        plan.push_back(item_row(lie_pkg::OP_TRIGGER, 32'd1000, 1'b0, 24'h0));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'd1299, 1'b1, 24'hFE00FE));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'd1300, 1'b1, 24'hFEFEFE));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'd1100, 1'b1, 24'hFEFEFE));
        plan.push_back(item_row(lie_pkg::OP_TRIGGER, 32'hFFFF_FF00, 1'b0, 24'h0));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h10, 1'b1, 24'hFE00FE));
        plan.push_back(cfg_row(lie_pkg::REG_BRIGHTNESS, 32'h0));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h20, 1'b1, 24'h000000));
        plan.push_back(cfg_row(lie_pkg::REG_BRIGHTNESS, 32'd128));
        plan.push_back(cfg_row(lie_pkg::REG_EFFECT_MODE, {29'h0, lie_pkg::MODE_RAINBOW}));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h30, 1'b0, 24'h0));
        plan.push_back(cfg_row(lie_pkg::REG_BREATH_SPD, 32'hFF));
        plan.push_back(cfg_row(lie_pkg::REG_EFFECT_MODE, {29'h0, lie_pkg::MODE_BREATH}));
        plan.push_back(cfg_row(lie_pkg::REG_BRIGHTNESS, 32'hFF));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h40, 1'b0, 24'h0));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h41, 1'b0, 24'h0));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h42, 1'b0, 24'h0));
        // a zero speed write leaves the speed alone
        plan.push_back(cfg_row(lie_pkg::REG_BREATH_SPD, 32'h0));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h43, 1'b0, 24'h0));
        // motion blanking: boundary, wrap, disabled by zero and by max timeout
        plan.push_back(cfg_row(lie_pkg::REG_EFFECT_MODE, {29'h0, lie_pkg::MODE_SOLID}));
        plan.push_back(cfg_row(lie_pkg::REG_OFF_MOTION, 32'h1));
        plan.push_back(cfg_row(lie_pkg::REG_OFF_TIMEOUT, 32'd100));
        plan.push_back(item_row(lie_pkg::OP_MOTION, 32'd5000, 1'b0, 24'h0));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'd5100, 1'b1, 24'hFFFFFF));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'd5101, 1'b1, 24'h000000));
        plan.push_back(item_row(lie_pkg::OP_MOTION, 32'hFFFF_FFF0, 1'b0, 24'h0));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h50, 1'b1, 24'hFFFFFF));
        plan.push_back(cfg_row(lie_pkg::REG_OFF_TIMEOUT, 32'h0));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h7FFF_FFFF, 1'b1, 24'hFFFFFF));
        plan.push_back(cfg_row(lie_pkg::REG_OFF_TIMEOUT, 32'hFFFF_FFFF));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h8000_0000, 1'b1, 24'hFFFFFF));
        plan.push_back(cfg_row(lie_pkg::REG_OFF_MOTION, 32'h0));
        plan.push_back(cfg_row(lie_pkg::REG_OFF_TIMEOUT, 32'h1));
        plan.push_back(item_row(lie_pkg::OP_UPDATE, 32'h9000_0000, 1'b1, 24'hFFFFFF));

        // reset
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                settle_engine();
                cfg_write(plan[r].idx, plan[r].data);
            end else begin
                send_item(plan[r].op, plan[r].data, pick_gap(), plan[r].typed,
                          plan[r].colour);
            end
        end

        // randomised phases, each with fresh register settings
        clk_ms = $urandom();
        for (p = 0; p < N_PHASES; p++) begin
            settle_engine();
            if (p == 0) begin
                cfg_write(lie_pkg::REG_BASE_COLOR, 32'hFF_FFFF);
                cfg_write(lie_pkg::REG_MACRO_COLOR, 32'hFF_FFFF);
                cfg_write(lie_pkg::REG_BRIGHTNESS, 32'hFF);
                cfg_write(lie_pkg::REG_BREATH_SPD, 32'hFF);
                cfg_write(lie_pkg::REG_OFF_MOTION, 32'h1);
                cfg_write(lie_pkg::REG_OFF_TIMEOUT, 32'hFFFF_FFFF);
            end else if (p == 1) begin
                cfg_write(lie_pkg::REG_BASE_COLOR, 32'h0);
                cfg_write(lie_pkg::REG_MACRO_COLOR, 32'h0);
                cfg_write(lie_pkg::REG_BRIGHTNESS, 32'h0);
                cfg_write(lie_pkg::REG_BREATH_SPD, 32'h1);
                cfg_write(lie_pkg::REG_OFF_MOTION, 32'h0);
                cfg_write(lie_pkg::REG_OFF_TIMEOUT, 32'h0);
            end else begin
                case ($urandom_range(0, 7))
                    0:       timeout = 32'h0;
                    1:       timeout = 32'hFFFF_FFFF;
                    2:       timeout = $urandom();
                    default: timeout = $urandom_range(20, 1500);
                endcase
                cfg_write(lie_pkg::REG_BASE_COLOR, {8'h0, 24'($urandom())});
                cfg_write(lie_pkg::REG_MACRO_COLOR, {8'h0, 24'($urandom())});
                cfg_write(lie_pkg::REG_BRIGHTNESS,
                          ($urandom_range(0, 3) == 0) ? 32'hFF : $urandom_range(0, 255));
                cfg_write(lie_pkg::REG_BREATH_SPD, $urandom_range(0, 255));
                cfg_write(lie_pkg::REG_OFF_MOTION,
                          ($urandom_range(0, 2) != 0) ? 32'h1 : 32'h0);
                cfg_write(lie_pkg::REG_OFF_TIMEOUT, timeout);
            end
            cfg_write(lie_pkg::REG_EFFECT_MODE, {29'h0, phase_modes[p]});
            if (p == HOLD_PHASE)
                hold_req = 1'b1;

            done = 0;
            while (done < ITEMS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = OP_SPARE;
                else if (roll < 15)
                    op = lie_pkg::OP_TRIGGER;
                else if (roll < 27)
                    op = lie_pkg::OP_MOTION;
                else
                    op = lie_pkg::OP_UPDATE;
                // millisecond clock moving forward, with jumps and wraps
                roll = $urandom_range(0, 63);
                if (roll == 0)
                    clk_ms = $urandom();
                else if (roll == 1)
                    clk_ms = 32'hFFFF_FF00 | $urandom_range(0, 255);
                else
                    clk_ms = clk_ms + $urandom_range(0, 120);
                now = (roll == 2) ? $urandom() : clk_ms;
                send_item(op, now, (done % 40 < 8) ? 0 : pick_gap(), 1'b0, 24'h0);
                if (op != OP_SPARE)
                    done++;
            end
        end

        // drain
        i_valid = 1'b0;
        waited  = 0;
        while (colour_due.size() != 0 && waited < END_WAIT_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (colour_due.size() != 0)
            report_mismatch("colour never delivered", 24'h0, colour_due[0]);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
